// ----- rtl/dhsc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the DHCPv6 header and option scanner.
// No dependencies; used by the interfaces and the top level.
package dhsc_pkg;

   localparam int unsigned DATA_WIDTH     = 8;
   localparam int unsigned PORT_WIDTH     = 16;
   localparam int unsigned TXID_WIDTH     = 24;
   localparam int unsigned CODE_WIDTH     = 16;
   localparam int unsigned LENGTH_WIDTH   = 16;
   localparam int unsigned COUNT_WIDTH    = 5;
   localparam int unsigned LEVEL_WIDTH    = 2;
   localparam int unsigned CSR_IDX_WIDTH  = 8;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CLIENT_PORT = 8'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SERVER_PORT = 8'd1;

   localparam logic [PORT_WIDTH-1:0] CLIENT_PORT_RESET = 16'd546;
   localparam logic [PORT_WIDTH-1:0] SERVER_PORT_RESET = 16'd547;

   localparam logic [DATA_WIDTH-1:0] MSG_TYPE_FIRST       = 8'd1;
   localparam logic [DATA_WIDTH-1:0] MSG_TYPE_RELAY_FORW  = 8'd12;
   localparam logic [DATA_WIDTH-1:0] MSG_TYPE_RELAY_REPL  = 8'd13;

   localparam logic [1:0] HDR_LAST_INDEX = 2'd3;

   localparam logic [LEVEL_WIDTH-1:0] LEVEL_NONE      = 2'd0;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_PLAUSIBLE = 2'd1;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_ON_PORT   = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_OPTHDR  = 2'd1,
      PH_OPTDATA = 2'd2,
      PH_IDLE    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      OH_CODE_HI = 2'd0,
      OH_CODE_LO = 2'd1,
      OH_LEN_HI  = 2'd2,
      OH_LEN_LO  = 2'd3
   } opt_hdr_type;

   typedef struct packed {
      logic                   header_ok;
      logic [DATA_WIDTH-1:0]  message_type;
      logic                   type_known;
      logic                   relay_message;
      logic [TXID_WIDTH-1:0]  transaction_id;
      logic [COUNT_WIDTH-1:0] option_count;
      logic [CODE_WIDTH-1:0]  lead_option_code;
      logic [LEVEL_WIDTH-1:0] detect_level;
   } result_type;

endpackage

// ----- rtl/dhsc_req_if.sv -----
`timescale 1ns / 1ps
// Input channel: one payload byte per transaction with its side information.
// Depends on dhsc_pkg for field widths.
interface dhsc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [dhsc_pkg::DATA_WIDTH-1:0]      data_byte;
   logic                                 last_byte;
   logic [dhsc_pkg::PORT_WIDTH-1:0]      dest_port;
   logic                                 is_udp;

   modport source (output valid, data_byte, last_byte, dest_port, is_udp, input ready);
   modport sink   (input valid, data_byte, last_byte, dest_port, is_udp, output ready);
endinterface

// ----- rtl/dhsc_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel: one scan summary per packet.
// Depends on dhsc_pkg for field widths.
interface dhsc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 header_ok;
   logic [dhsc_pkg::DATA_WIDTH-1:0]      message_type;
   logic                                 type_known;
   logic                                 relay_message;
   logic [dhsc_pkg::TXID_WIDTH-1:0]      transaction_id;
   logic [dhsc_pkg::COUNT_WIDTH-1:0]     option_count;
   logic [dhsc_pkg::CODE_WIDTH-1:0]      lead_option_code;
   logic [dhsc_pkg::LEVEL_WIDTH-1:0]     detect_level;

   modport source (output valid, header_ok, message_type, type_known, relay_message,
                   transaction_id, option_count, lead_option_code, detect_level,
                   input ready);
   modport sink   (input valid, header_ok, message_type, type_known, relay_message,
                   transaction_id, option_count, lead_option_code, detect_level,
                   output ready);
endinterface

// ----- rtl/dhsc_csr_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on dhsc_pkg for field widths.
interface dhsc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [dhsc_pkg::CSR_IDX_WIDTH-1:0]   index;
   logic [dhsc_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/dhcpv6_header_option_scanner.sv -----
`timescale 1ns / 1ps
// DHCPv6 header and option scanner: walks the message header and option TLVs
// of a UDP payload byte by byte. The result of a packet is valid in the cycle
// after its last byte is accepted. Throughput: one byte per cycle while
// results are taken; a result that waits holds off the input until it is taken.
// Reset (synchronous, active high) clears the parse state and the result valid,
// and sets the client and server ports to 546 and 547.
// Depends on dhsc_pkg, dhsc_req_if, dhsc_rsp_if and dhsc_csr_if.
module dhcpv6_header_option_scanner #(
   parameter int unsigned MAX_OPTIONS = 16
) (
   input logic           clock,
   input logic           reset,
   dhsc_req_if.sink      req_if,
   dhsc_rsp_if.source    rsp_if,
   dhsc_csr_if.sink      csr_if
);

   localparam int unsigned CNT_W     = $clog2(MAX_OPTIONS + 1);
   localparam int unsigned CNT_EXT_W = 9;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OPTIONS);

   logic [dhsc_pkg::PORT_WIDTH-1:0]   client_port_ff;
   logic [dhsc_pkg::PORT_WIDTH-1:0]   server_port_ff;

   dhsc_pkg::phase_type               phase_ff, phase_in;
   logic [1:0]                        hdr_idx_ff, hdr_idx_in;
   dhsc_pkg::opt_hdr_type             opt_idx_ff, opt_idx_in;
   logic [dhsc_pkg::DATA_WIDTH-1:0]   type_ff, type_in;
   logic [dhsc_pkg::TXID_WIDTH-1:0]   id_ff, id_in;
   logic [dhsc_pkg::CODE_WIDTH-1:0]   code_ff, code_in;
   logic [dhsc_pkg::DATA_WIDTH-1:0]   len_hi_ff, len_hi_in;
   logic [dhsc_pkg::LENGTH_WIDTH-1:0] left_ff, left_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [dhsc_pkg::CODE_WIDTH-1:0]   first_ff, first_in;

   dhsc_pkg::result_type              rsp_ff, rsp_in;
   logic                              rsp_valid_ff;

   logic                              req_fire;
   logic                              opt_done;
   logic [dhsc_pkg::LENGTH_WIDTH-1:0] opt_len;
   dhsc_pkg::phase_type               phase_post;
   logic [1:0]                        hdr_idx_post;
   dhsc_pkg::opt_hdr_type             opt_idx_post;
   logic [CNT_W-1:0]                  count_post;
   logic                              hdr_ok;
   logic                              known;
   logic                              relay;
   logic                              port_hit;
   logic [CNT_EXT_W-1:0]              count_ext;

   assign req_fire      = req_if.valid && req_if.ready;
   assign req_if.ready  = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         client_port_ff <= dhsc_pkg::CLIENT_PORT_RESET;
         server_port_ff <= dhsc_pkg::SERVER_PORT_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            dhsc_pkg::CSR_CLIENT_PORT: client_port_ff <= csr_if.data;
            dhsc_pkg::CSR_SERVER_PORT: server_port_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= dhsc_pkg::PH_HEADER;
         hdr_idx_ff <= 2'd0;
         opt_idx_ff <= dhsc_pkg::OH_CODE_HI;
         count_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         opt_idx_ff <= opt_idx_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      id_ff     <= id_in;
      code_ff   <= code_in;
      len_hi_ff <= len_hi_in;
      left_ff   <= left_in;
      first_ff  <= first_in;
   end

   always_comb begin
      phase_post   = phase_ff;
      hdr_idx_post = hdr_idx_ff;
      opt_idx_post = opt_idx_ff;
      count_post   = count_ff;
      type_in      = type_ff;
      id_in        = id_ff;
      code_in      = code_ff;
      len_hi_in    = len_hi_ff;
      left_in      = left_ff;
      first_in     = first_ff;
      opt_done     = 1'b0;
      opt_len      = {len_hi_ff, req_if.data_byte};

      if (req_fire) begin
         unique case (phase_ff)
            dhsc_pkg::PH_HEADER: begin
               if (hdr_idx_ff == 2'd0) begin
                  type_in = req_if.data_byte;
               end else begin
                  id_in = {id_ff[dhsc_pkg::TXID_WIDTH-dhsc_pkg::DATA_WIDTH-1:0],
                           req_if.data_byte};
               end
               if (hdr_idx_ff == dhsc_pkg::HDR_LAST_INDEX) begin
                  hdr_idx_post = 2'd0;
                  if (type_ff == dhsc_pkg::MSG_TYPE_RELAY_FORW ||
                      type_ff == dhsc_pkg::MSG_TYPE_RELAY_REPL || count_ff >= CNT_MAX) begin
                     phase_post = dhsc_pkg::PH_IDLE;
                  end else begin
                     phase_post = dhsc_pkg::PH_OPTHDR;
                  end
               end else begin
                  hdr_idx_post = hdr_idx_ff + 2'd1;
               end
            end
            dhsc_pkg::PH_OPTHDR: begin
               opt_idx_post = dhsc_pkg::opt_hdr_type'(opt_idx_ff + 2'd1);
               unique case (opt_idx_ff)
                  dhsc_pkg::OH_CODE_HI: code_in[15:8] = req_if.data_byte;
                  dhsc_pkg::OH_CODE_LO: code_in[7:0]  = req_if.data_byte;
                  dhsc_pkg::OH_LEN_HI:  len_hi_in     = req_if.data_byte;
                  dhsc_pkg::OH_LEN_LO: begin
                     if (opt_len == '0) begin
                        opt_done = 1'b1;
                     end else begin
                        left_in    = opt_len;
                        phase_post = dhsc_pkg::PH_OPTDATA;
                     end
                  end
                  default: ;
               endcase
            end
            dhsc_pkg::PH_OPTDATA: begin
               left_in = left_ff - 1'b1;
               if (left_ff == dhsc_pkg::LENGTH_WIDTH'(1)) begin
                  opt_done = 1'b1;
               end
            end
            default: ;
         endcase

         if (opt_done) begin
            if (count_ff < CNT_MAX) begin
               count_post = count_ff + 1'b1;
               if (count_ff == '0) begin
                  first_in = code_ff;
               end
            end
            phase_post   = (count_post >= CNT_MAX) ? dhsc_pkg::PH_IDLE : dhsc_pkg::PH_OPTHDR;
            opt_idx_post = dhsc_pkg::OH_CODE_HI;
         end
      end

      if (req_fire && req_if.last_byte) begin
         phase_in   = dhsc_pkg::PH_HEADER;
         hdr_idx_in = 2'd0;
         opt_idx_in = dhsc_pkg::OH_CODE_HI;
         count_in   = '0;
      end else begin
         phase_in   = phase_post;
         hdr_idx_in = hdr_idx_post;
         opt_idx_in = opt_idx_post;
         count_in   = count_post;
      end
   end

   assign hdr_ok    = phase_post != dhsc_pkg::PH_HEADER;
   assign known     = type_in >= dhsc_pkg::MSG_TYPE_FIRST &&
                      type_in <= dhsc_pkg::MSG_TYPE_RELAY_REPL;
   assign relay     = type_in == dhsc_pkg::MSG_TYPE_RELAY_FORW ||
                      type_in == dhsc_pkg::MSG_TYPE_RELAY_REPL;
   assign port_hit  = req_if.dest_port == client_port_ff || req_if.dest_port == server_port_ff;
   assign count_ext = CNT_EXT_W'(count_post);

   always_comb begin
      rsp_in = '0;
      if (hdr_ok) begin
         rsp_in.header_ok     = 1'b1;
         rsp_in.message_type  = type_in;
         rsp_in.type_known    = known;
         rsp_in.relay_message = relay;
         if (!relay) begin
            rsp_in.transaction_id   = id_in;
            rsp_in.option_count     = count_ext[dhsc_pkg::COUNT_WIDTH-1:0];
            rsp_in.lead_option_code = (count_post == '0) ? '0 : first_in;
            if (req_if.is_udp && known) begin
               rsp_in.detect_level = port_hit ? dhsc_pkg::LEVEL_ON_PORT
                                              : dhsc_pkg::LEVEL_PLAUSIBLE;
            end else begin
               rsp_in.detect_level = dhsc_pkg::LEVEL_NONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && req_if.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_if.last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.header_ok        = rsp_ff.header_ok;
   assign rsp_if.message_type     = rsp_ff.message_type;
   assign rsp_if.type_known       = rsp_ff.type_known;
   assign rsp_if.relay_message    = rsp_ff.relay_message;
   assign rsp_if.transaction_id   = rsp_ff.transaction_id;
   assign rsp_if.option_count     = rsp_ff.option_count;
   assign rsp_if.lead_option_code = rsp_ff.lead_option_code;
   assign rsp_if.detect_level     = rsp_ff.detect_level;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_if.last_byte |=> rsp_valid_ff)
      else $error("Last byte accepted without a result.");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("Option count exceeds its maximum.");

   a_relay_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.relay_message |->
         rsp_ff.transaction_id == '0 && rsp_ff.option_count == '0 &&
         rsp_ff.detect_level == dhsc_pkg::LEVEL_NONE)
      else $error("Relay result carries parsed fields.");

   a_short_no_detect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.header_ok |-> rsp_ff.detect_level == dhsc_pkg::LEVEL_NONE)
      else $error("Short payload detected as DHCPv6.");

endmodule
